// ===== src/sewb_pkg.sv =====
// Shared types and constants for the spike event window buffer.
package sewb_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int CELL_BITS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;

  // Port field widths
  localparam int OP_BITS      = 3;
  localparam int CELL_IN_BITS = 16;
  localparam int TIME_IN_BITS = 32;
  localparam int STATUS_BITS  = 2;
  localparam int IDX_OUT_BITS = 11;
  localparam int CFG_BITS     = 32;

  localparam logic [CFG_BITS-1:0] STEP_LENGTH_RESET = 32'd1000;

  // Configuration register index, taken from paddr[2]
  localparam logic REG_STEP_LENGTH = 1'b0;

  localparam logic [OP_BITS-1:0] OP_CLEAR        = 3'd0;
  localparam logic [OP_BITS-1:0] OP_FIRE         = 3'd1;
  localparam logic [OP_BITS-1:0] OP_NEW_FRAME    = 3'd2;
  localparam logic [OP_BITS-1:0] OP_STEP         = 3'd3;
  localparam logic [OP_BITS-1:0] OP_COUNT_WINDOW = 3'd4;
  localparam logic [OP_BITS-1:0] OP_COUNT_RANGE  = 3'd5;

  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_ORDER = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_START,
    ST_ADD_END,
    ST_SCAN_FIRST,
    ST_SCAN_END,
    ST_COUNT,
    ST_DONE
  } state_t;

endpackage

// ===== src/spike_event_window_buffer.sv =====
// Spike event window buffer: event store, window sequencer and count engine.
//
// Items arrive on the s_ channel (operation and use_step_start in s_tuser, cell,
// time and range bounds in s_tdata) and each produces exactly one result transfer
// on the m_ channel. step_length is written over the APB port at address 0.
// One item is worked on at a time; s_tready is high only while the sequencer idles.
// A clear, fire or unused code goes straight to the result register; new frame
// and step run the first and end index walks when events are stored, a step
// first forming the new window start and end; a window count with data walks from
// the first to the end index and a range count walks all stored events, so up to
// CAPACITY entries. The walks read the event memory once a cycle through its
// single registered read port; the two saturating time sums of a step share one
// adder, taken in ST_ADD_START and ST_ADD_END.
// Reset empties the buffer, zeroes the window and sets step_length to 1000; the
// event memory itself is not cleared, as only entries below the count are read.
// A result waits in the output register while m_tready is low; the next item may
// be taken meanwhile, but its result is held back until the register frees up.
module spike_event_window_buffer
  import sewb_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int CELL_BITS = CELL_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // [15:0] cell_id, [47:16] spike_time, [79:48] range_start, [111:80] range_end
  input  logic [111:0]  s_tdata,
  // [2:0] operation, [3] use_step_start
  input  logic [3:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // [1:0] status, [12:2] count, [13] data_available, [24:14] window_first,
  // [35:25] window_end, [46:36] stored_events, [47] zero
  output logic [47:0]   m_tdata,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int MW = CELL_BITS + TIME_BITS;

  state_t state, state_next;

  // Control and window state
  logic [CFG_BITS-1:0]  step_length;
  logic [IW-1:0]        event_count;
  logic [IW-1:0]        first_index;
  logic [IW-1:0]        end_index;
  logic                 window_has_data;
  logic [TIME_BITS-1:0] win_start;
  logic [TIME_BITS-1:0] win_end;
  logic [TIME_BITS-1:0] last_time;

  // Operation context
  logic [OP_BITS-1:0]     op_code;
  logic [CELL_BITS-1:0]   op_cell;
  logic [TIME_BITS-1:0]   range_lo;
  logic [TIME_BITS-1:0]   range_hi;
  logic [STATUS_BITS-1:0] op_status;
  logic [IW-1:0]          op_total;
  logic [IW-1:0]          scan_idx;
  logic [IW-1:0]          scan_next;
  logic [IW-1:0]          scan_limit;

  // Event memory
  logic [MW-1:0] mem [CAPACITY];
  logic [MW-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [CELL_BITS-1:0] rd_cell;
  logic [TIME_BITS-1:0] rd_time;

  // Input field unpacking
  logic [OP_BITS-1:0]                in_op;
  logic                              in_use_start;
  logic [CELL_BITS+CELL_IN_BITS-1:0] cell_ext;
  logic [TIME_BITS+TIME_IN_BITS-1:0] time_ext;
  logic [TIME_BITS+TIME_IN_BITS-1:0] lo_ext;
  logic [TIME_BITS+TIME_IN_BITS-1:0] hi_ext;
  logic [TIME_BITS+CFG_BITS-1:0]     step_ext;
  logic [CELL_BITS-1:0]              in_cell;
  logic [TIME_BITS-1:0]              in_time;
  logic [TIME_BITS-1:0]              step_t;
  logic [TIME_BITS-1:0]              fire_time;

  logic [TIME_BITS:0]   sum_w;
  logic [TIME_BITS-1:0] sat_sum;

  logic accept;
  logic out_free;
  logic out_load;
  logic buf_full;
  logic out_of_order;
  logic hit_first;
  logic hit_end;
  logic count_more;
  logic count_match;

  logic [IW+IDX_OUT_BITS-1:0] total_ext;
  logic [IW+IDX_OUT_BITS-1:0] first_ext;
  logic [IW+IDX_OUT_BITS-1:0] end_ext;
  logic [IW+IDX_OUT_BITS-1:0] count_ext;

  assign in_op        = s_tuser[2:0];
  assign in_use_start = s_tuser[3];
  assign cell_ext = {{CELL_BITS{1'b0}}, s_tdata[15:0]};
  assign time_ext = {{TIME_BITS{1'b0}}, s_tdata[47:16]};
  assign lo_ext   = {{TIME_BITS{1'b0}}, s_tdata[79:48]};
  assign hi_ext   = {{TIME_BITS{1'b0}}, s_tdata[111:80]};
  assign step_ext = {{TIME_BITS{1'b0}}, step_length};
  assign in_cell  = cell_ext[CELL_BITS-1:0];
  assign in_time  = time_ext[TIME_BITS-1:0];
  assign step_t   = step_ext[TIME_BITS-1:0];
  assign fire_time = in_use_start ? win_start : in_time;

  // Shared saturating adder: both window sums of a step are start + step_length
  assign sum_w   = {1'b0, win_start} + {1'b0, step_t};
  assign sat_sum = sum_w[TIME_BITS] ? {TIME_BITS{1'b1}} : sum_w[TIME_BITS-1:0];

  assign rd_cell = rd_q[MW-1:TIME_BITS];
  assign rd_time = rd_q[TIME_BITS-1:0];

  assign accept       = s_tvalid && s_tready;
  assign out_free     = !m_tvalid || m_tready;
  assign buf_full     = event_count >= IW'(CAPACITY);
  assign out_of_order = (event_count != '0) && (last_time > fire_time);
  assign wr_en        = accept && (in_op == OP_FIRE) && !buf_full && !out_of_order;

  // rd_q always holds the entry at scan_idx
  assign hit_first   = (scan_idx < event_count) && (win_start > rd_time);
  assign hit_end     = (scan_idx < event_count) && (win_end > rd_time);
  assign count_more  = scan_idx < scan_limit;
  assign count_match = (rd_cell == op_cell) &&
                       ((op_code != OP_COUNT_RANGE) ||
                        ((range_lo <= rd_time) && (rd_time <= range_hi)));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_NEW_FRAME:    state_next = (event_count == '0) ? ST_DONE : ST_SCAN_FIRST;
            OP_STEP:         state_next = ST_ADD_START;
            OP_COUNT_WINDOW: state_next = window_has_data ? ST_COUNT : ST_DONE;
            OP_COUNT_RANGE:  state_next = ST_COUNT;
            default:         state_next = ST_DONE;
          endcase
        end
      end
      ST_ADD_START:  state_next = ST_ADD_END;
      ST_ADD_END:    state_next = (event_count == '0) ? ST_DONE : ST_SCAN_FIRST;
      ST_SCAN_FIRST: state_next = hit_first ? ST_SCAN_FIRST : ST_SCAN_END;
      ST_SCAN_END:   state_next = hit_end ? ST_SCAN_END : ST_DONE;
      ST_COUNT:      state_next = count_more ? ST_COUNT : ST_DONE;
      ST_DONE:       state_next = out_free ? ST_IDLE : ST_DONE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    out_load  = 1'b0;
    scan_next = scan_idx;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (accept) begin
          case (in_op)
            OP_NEW_FRAME:    scan_next = '0;
            OP_COUNT_WINDOW: scan_next = first_index;
            OP_COUNT_RANGE:  scan_next = '0;
            default:         scan_next = scan_idx;
          endcase
        end
      end
      ST_ADD_END:    scan_next = first_index;
      ST_SCAN_FIRST: if (hit_first) scan_next = scan_idx + IW'(1);
      ST_SCAN_END:   if (hit_end) scan_next = scan_idx + IW'(1);
      ST_COUNT:      if (count_more) scan_next = scan_idx + IW'(1);
      ST_DONE:       out_load = out_free;
      default:       scan_next = scan_idx;
    endcase
  end

  assign rd_addr = scan_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[event_count[AW-1:0]] <= {in_cell, fire_time};
    end
    rd_q <= mem[rd_addr];
  end

  assign total_ext = {{IDX_OUT_BITS{1'b0}}, op_total};
  assign first_ext = {{IDX_OUT_BITS{1'b0}}, first_index};
  assign end_ext   = {{IDX_OUT_BITS{1'b0}}, end_index};
  assign count_ext = {{IDX_OUT_BITS{1'b0}}, event_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      step_length     <= STEP_LENGTH_RESET;
      event_count     <= '0;
      first_index     <= '0;
      end_index       <= '0;
      window_has_data <= 1'b0;
      win_start       <= '0;
      win_end         <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_next;

      if (psel && penable && pwrite && pready && (paddr[2] == REG_STEP_LENGTH)) begin
        step_length <= pwdata;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_code   <= in_op;
            op_cell   <= in_cell;
            range_lo  <= lo_ext[TIME_BITS-1:0];
            range_hi  <= hi_ext[TIME_BITS-1:0];
            // full check wins over the order check
            op_status <= (in_op != OP_FIRE) ? STATUS_OK :
                         buf_full           ? STATUS_FULL :
                         out_of_order       ? STATUS_ORDER : STATUS_OK;
            op_total  <= '0;
            case (in_op)
              OP_CLEAR: begin
                event_count     <= '0;
                first_index     <= '0;
                end_index       <= '0;
                window_has_data <= 1'b0;
              end
              OP_FIRE: begin
                if (!buf_full && !out_of_order) begin
                  event_count <= event_count + IW'(1);
                  last_time   <= fire_time;
                end
              end
              OP_NEW_FRAME: begin
                win_start   <= '0;
                win_end     <= step_t;
                first_index <= '0;
                end_index   <= '0;
                if (event_count == '0) window_has_data <= 1'b0;
              end
              OP_COUNT_WINDOW: scan_limit <= end_index;
              OP_COUNT_RANGE:  scan_limit <= event_count;
              default: ;
            endcase
          end
        end
        ST_ADD_START: win_start <= sat_sum;
        ST_ADD_END: begin
          win_end <= sat_sum;
          if (event_count == '0) window_has_data <= 1'b0;
        end
        ST_SCAN_FIRST: if (!hit_first) first_index <= scan_idx;
        ST_SCAN_END: begin
          if (!hit_end) begin
            end_index       <= scan_idx;
            window_has_data <= scan_idx > first_index;
          end
        end
        ST_COUNT: if (count_more && count_match) op_total <= op_total + IW'(1);
        default: ;
      endcase

      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {1'b0, count_ext[IDX_OUT_BITS-1:0], end_ext[IDX_OUT_BITS-1:0],
                     first_ext[IDX_OUT_BITS-1:0], window_has_data,
                     total_ext[IDX_OUT_BITS-1:0], op_status};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_STEP_LENGTH) ? step_length : '0;

endmodule

// ===== src/sewb_checker.sv =====
// Port-level checks for the spike event window buffer, bound to the top level.
module sewb_checker
  import sewb_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  logic [IDX_OUT_BITS-1:0] r_count;
  logic                    r_avail;
  logic [IDX_OUT_BITS-1:0] r_first;
  logic [IDX_OUT_BITS-1:0] r_end;
  logic [IDX_OUT_BITS-1:0] r_stored;

  assign r_count  = m_tdata[12:2];
  assign r_avail  = m_tdata[13];
  assign r_first  = m_tdata[24:14];
  assign r_end    = m_tdata[35:25];
  assign r_stored = m_tdata[46:36];

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Window indices stay ordered inside the stored events
  a_window_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (r_first <= r_end) && (r_end <= r_stored))
    else $error("window indices out of order");

  // Data flag agrees with a non-empty index window
  a_avail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> r_avail == (r_end > r_first))
    else $error("data_available disagrees with window indices");

  // Counts never exceed the stored events, which never exceed capacity
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (CAPACITY < 2048) |->
      (r_count <= r_stored) && (r_stored <= IDX_OUT_BITS'(CAPACITY)))
    else $error("count or fill beyond bounds");

endmodule

bind spike_event_window_buffer sewb_checker #(.CAPACITY(CAPACITY)) u_sewb_checker (.*);

// ===== tb/spike_event_window_buffer_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the spike event window buffer, with its own window predictor.
module spike_event_window_buffer_test;
  import sewb_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam logic [OP_BITS-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_7 = 3'd7;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = CAP + 80;
  localparam logic [15:0] FILL_CELL = 16'hA5C3;

  typedef struct {
    logic [OP_BITS-1:0] op;
    logic [15:0]        cell_id;
    logic [31:0]        stime;
    logic               use_start;
    logic [31:0]        lo;
    logic [31:0]        hi;
    bit                 drain_first;
  } spike_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] count;
    logic        avail;
    logic [10:0] first;
    logic [10:0] wend;
    logic [10:0] stored;
  } window_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  wire          s_tready;
  // [15:0] cell_id, [47:16] spike_time, [79:48] range_start, [111:80] range_end
  logic [111:0] s_tdata = '0;
  // [2:0] operation, [3] use_step_start
  logic [3:0]   s_tuser = '0;
  wire          m_tvalid;
  logic         m_tready = 1'b0;
  // [1:0] status, [12:2] count, [13] data_available, [24:14] window_first,
  // [35:25] window_end, [46:36] stored_events, [47] zero
  wire  [47:0]  m_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  wire  [31:0]  prdata;
  wire          pready;

  spike_event_window_buffer i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted block state
  logic [15:0] ev_cell [CAP];
  logic [31:0] ev_time [CAP];
  int          n_stored = 0;
  int          first_idx = 0;
  int          end_idx = 0;
  logic        has_data = 1'b0;
  logic [31:0] win_start = '0;
  logic [31:0] win_end = '0;
  logic [31:0] step_len = STEP_LENGTH_RESET;

  spike_item_t    spike_items[$];
  window_result_t expected_results[$];
  spike_item_t    on_bus;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int mismatches = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int n_full = 0;
  int n_order = 0;
  int max_stored = 0;
  int cfg_writes = 0;

  // Stimulus generator bookkeeping
  longint      gen_time = 0;
  int          gen_count = 0;
  int          gen_span = 2;
  int          rand_items = 0;
  bit          drain_frames = 1'b0;
  logic [15:0] cell_pool [3];

  initial forever #6 clk = ~clk;

  initial begin
    #(60_000_000);
    $display("Timeout with %0d results still expected", expected_results.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Walk both indices forward so [first_idx, end_idx) covers the window.
  function automatic void locate_window();
    if (n_stored == 0) begin
      has_data = 1'b0;
      return;
    end
    while (first_idx < n_stored && win_start > ev_time[first_idx]) first_idx++;
    end_idx = first_idx;
    while (end_idx < n_stored && win_end > ev_time[end_idx]) end_idx++;
    has_data = end_idx > first_idx;
  endfunction

  function automatic window_result_t apply_spike_op(input spike_item_t it);
    window_result_t r;
    logic [31:0]    t;
    int             i;
    r = '0;
    case (it.op)
      OP_CLEAR: begin
        n_stored = 0;
        first_idx = 0;
        end_idx = 0;
        has_data = 1'b0;
      end
      OP_FIRE: begin
        t = it.use_start ? win_start : it.stime;
        // full check wins over the order check
        if (n_stored >= CAP) begin
          r.status = STATUS_FULL;
          n_full++;
        end else if (n_stored > 0 && ev_time[n_stored-1] > t) begin
          r.status = STATUS_ORDER;
          n_order++;
        end else begin
          ev_cell[n_stored] = it.cell_id;
          ev_time[n_stored] = t;
          n_stored++;
          if (n_stored > max_stored) max_stored = n_stored;
        end
      end
      OP_NEW_FRAME: begin
        win_start = '0;
        win_end = step_len;
        first_idx = 0;
        end_idx = 0;
        locate_window();
      end
      OP_STEP: begin
        win_start = sat_sum(win_start, step_len);
        win_end = sat_sum(win_start, step_len);
        locate_window();
      end
      OP_COUNT_WINDOW: begin
        if (has_data)
          for (i = first_idx; i < end_idx; i++)
            if (ev_cell[i] == it.cell_id) r.count++;
      end
      OP_COUNT_RANGE: begin
        for (i = 0; i < n_stored; i++)
          if (ev_cell[i] == it.cell_id && it.lo <= ev_time[i] && ev_time[i] <= it.hi)
            r.count++;
      end
      default: ;
    endcase
    r.avail = has_data;
    r.first = 11'(first_idx);
    r.wend = 11'(end_idx);
    r.stored = 11'(n_stored);
    return r;
  endfunction

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_spike_op(on_bus));
        items_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (spike_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(spike_items[0].drain_first && expected_results.size() != 0)) begin
          on_bus = spike_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {on_bus.hi, on_bus.lo, on_bus.stime, on_bus.cell_id};
          s_tuser <= {on_bus.use_start, on_bus.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    window_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result transfer, expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", int'(want.status), int'(m_tdata[1:0]));
        check_field("count", int'(want.count), int'(m_tdata[12:2]));
        check_field("data_available", int'(want.avail), int'(m_tdata[13]));
        check_field("window_first", int'(want.first), int'(m_tdata[24:14]));
        check_field("window_end", int'(want.wend), int'(m_tdata[35:25]));
        check_field("stored_events", int'(want.stored), int'(m_tdata[46:36]));
        results_checked++;
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (spike_items.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_step_length(input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_STEP_LENGTH, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    step_len = value;
    cfg_writes++;
    gen_span = (value >= 4) ? int'(value >> 1) : 2;
    @(negedge clk);
  endtask

  task automatic queue_item(input spike_item_t it);
    spike_items.push_back(it);
    if (it.op != OP_SPARE_6 && it.op != OP_SPARE_7) rand_items++;
  endtask

  // Every field but op and drain_first random; callers overwrite the ones the operation uses.
  function automatic spike_item_t blank_item(input logic [OP_BITS-1:0] op);
    spike_item_t it;
    it.op = op;
    it.cell_id = 16'($urandom);
    it.stime = $urandom;
    it.use_start = 1'($urandom_range(0, 1));
    it.lo = $urandom;
    it.hi = $urandom;
    it.drain_first = 1'b0;
    return it;
  endfunction

  task automatic put(input logic [OP_BITS-1:0] op, input logic [15:0] cell_id,
                     input logic [31:0] stime, input logic use_start,
                     input logic [31:0] lo, input logic [31:0] hi);
    spike_item_t it;
    it.op = op;
    it.cell_id = cell_id;
    it.stime = stime;
    it.use_start = use_start;
    it.lo = lo;
    it.hi = hi;
    it.drain_first = 1'b0;
    queue_item(it);
  endtask

  function automatic logic [15:0] pool_cell();
    if ($urandom_range(0, 99) < 85) return cell_pool[$urandom_range(0, 2)];
    return 16'($urandom);
  endfunction

  // Mostly in-order fires; some take the step start, some go back in time.
  task automatic gen_fire(input logic [15:0] cell_id);
    spike_item_t it;
    int          pick;
    longint      nxt;
    it = blank_item(OP_FIRE);
    it.cell_id = cell_id;
    it.use_start = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 82) begin
      nxt = gen_time + $urandom_range(0, gen_span);
      if (nxt > 64'hFFFF_FFFF) nxt = 64'hFFFF_FFFF;
      gen_time = nxt;
      it.stime = nxt[31:0];
      gen_count++;
    end else if (pick < 90) begin
      it.use_start = 1'b1;
    end else if (gen_time > 0) begin
      it.stime = $urandom_range(0, 32'(gen_time - 1));
    end else begin
      it.stime = gen_time[31:0];
    end
    queue_item(it);
  endtask

  task automatic gen_count_query();
    spike_item_t it;
    longint      top;
    it = blank_item($urandom_range(0, 1) ? OP_COUNT_WINDOW : OP_COUNT_RANGE);
    it.cell_id = pool_cell();
    if (it.op == OP_COUNT_RANGE && $urandom_range(0, 99) < 80) begin
      it.lo = $urandom_range(0, 32'(gen_time));
      top = longint'(it.lo) + longint'($urandom_range(0, gen_span)) * 4;
      it.hi = (top > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : top[31:0];
    end
    queue_item(it);
  endtask

  // One frame: optional clear, a burst of fires, a new frame, then steps with queries.
  task automatic gen_frame();
    spike_item_t it;
    int          k;
    for (k = 0; k < 3; k++) cell_pool[k] = 16'($urandom);
    if (gen_count > 60 || $urandom_range(0, 99) < 70) begin
      queue_item(blank_item(OP_CLEAR));
      gen_count = 0;
      gen_time = $urandom_range(0, gen_span);
    end
    repeat ($urandom_range(0, 24)) gen_fire(pool_cell());
    it = blank_item(OP_NEW_FRAME);
    it.drain_first = drain_frames || $urandom_range(0, 99) < 3;
    queue_item(it);
    repeat ($urandom_range(1, 8)) begin
      queue_item(blank_item(OP_STEP));
      repeat ($urandom_range(0, 2)) gen_count_query();
      if ($urandom_range(0, 99) < 10) gen_fire(pool_cell());
      if ($urandom_range(0, 99) < 5)
        queue_item(blank_item($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7));
      if ($urandom_range(0, 99) < 3) queue_item(blank_item(OP_NEW_FRAME));
      if ($urandom_range(0, 99) < 3) begin
        queue_item(blank_item(OP_CLEAR));
        gen_count = 0;
      end
    end
  endtask

  initial begin
    logic [31:0] step_lengths [8];
    int          idle_of [4];
    int          stall_of [4];
    int          p;
    int          k;
    int          target;

    step_lengths = '{32'd1, 32'hFFFF_FFFF, 32'd37, 32'd0, 32'd1000, 32'd2, 32'd0,
                     32'h7FFF_FFFF};
    step_lengths[2] = $urandom | 32'd1;
    step_lengths[6] = $urandom_range(3, 5000);
    idle_of = '{0, 59, 0, 21};
    stall_of = '{0, 0, 59, 21};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty buffer, equal and early times, window moves, spare codes.
    put(OP_COUNT_RANGE, 16'h0000, '0, 1'b0, '0, 32'hFFFF_FFFF);
    put(OP_NEW_FRAME, '0, '0, 1'b0, '0, '0);
    put(OP_FIRE, 16'hFFFF, 32'd0, 1'b0, '0, '0);
    put(OP_FIRE, 16'h0000, 32'd0, 1'b0, '0, '0);
    put(OP_FIRE, 16'h1234, 32'd999, 1'b0, '0, '0);
    put(OP_FIRE, 16'hFFFF, 32'd1000, 1'b0, '0, '0);
    put(OP_FIRE, 16'hFFFF, 32'd500, 1'b0, '0, '0);
    put(OP_FIRE, 16'h0000, 32'hFFFF_FFFF, 1'b1, '0, '0);
    put(OP_NEW_FRAME, '0, '0, 1'b0, '0, '0);
    put(OP_COUNT_WINDOW, 16'hFFFF, '0, 1'b0, '0, '0);
    put(OP_COUNT_RANGE, 16'hFFFF, '0, 1'b0, 32'd0, 32'd1000);
    put(OP_COUNT_RANGE, 16'hFFFF, '0, 1'b0, 32'd1000, 32'd0);
    put(OP_STEP, '0, '0, 1'b0, '0, '0);
    put(OP_FIRE, 16'h5555, 32'd0, 1'b1, '0, '0);
    put(OP_COUNT_WINDOW, 16'hFFFF, '0, 1'b0, '0, '0);
    put(OP_SPARE_6, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put(OP_SPARE_7, '0, '0, 1'b0, '0, '0);
    put(OP_FIRE, 16'hAAAA, 32'hFFFF_FFFF, 1'b0, '0, '0);
    put(OP_STEP, '0, '0, 1'b0, '0, '0);
    put(OP_CLEAR, '0, '0, 1'b0, '0, '0);
    put(OP_COUNT_WINDOW, 16'hFFFF, '0, 1'b0, '0, '0);
    wait_idle();
    // window end sum saturates on the first step, both sums on the second
    write_step_length(32'hC000_0000);
    put(OP_FIRE, 16'h0001, 32'd5, 1'b0, '0, '0);
    put(OP_NEW_FRAME, '0, '0, 1'b0, '0, '0);
    put(OP_STEP, '0, '0, 1'b0, '0, '0);
    put(OP_STEP, '0, '0, 1'b0, '0, '0);
    put(OP_FIRE, 16'h0002, 32'd0, 1'b1, '0, '0);
    put(OP_COUNT_RANGE, 16'h0002, '0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();

    // Fill to capacity, hit the full buffer, then walk the whole store.
    write_step_length(32'hFFFF_FFFF);
    put(OP_CLEAR, '0, '0, 1'b0, '0, '0);
    gen_time = 0;
    for (k = 0; k < CAP; k++) begin
      gen_time = gen_time + $urandom_range(0, 3);
      put(OP_FIRE, FILL_CELL, gen_time[31:0], 1'b0, '0, '0);
    end
    put(OP_FIRE, FILL_CELL, 32'(gen_time + 1), 1'b0, '0, '0);
    put(OP_FIRE, FILL_CELL, 32'd0, 1'b0, '0, '0);
    put(OP_FIRE, 16'h0000, '0, 1'b1, '0, '0);
    put(OP_NEW_FRAME, '0, '0, 1'b0, '0, '0);
    put(OP_COUNT_WINDOW, FILL_CELL, '0, 1'b0, '0, '0);
    put(OP_COUNT_RANGE, FILL_CELL, '0, 1'b0, 32'd0, 32'hFFFF_FFFF);
    put(OP_COUNT_RANGE, ~FILL_CELL, '0, 1'b0, 32'd0, 32'hFFFF_FFFF);
    put(OP_COUNT_RANGE, FILL_CELL, '0, 1'b0, 32'(gen_time / 2), gen_time[31:0]);
    put(OP_STEP, '0, '0, 1'b0, '0, '0);
    put(OP_COUNT_WINDOW, FILL_CELL, '0, 1'b0, '0, '0);
    put(OP_CLEAR, '0, '0, 1'b0, '0, '0);
    wait_idle();

    rand_items = 0;
    for (p = 0; p < 8; p++) begin
      wait_idle();
      write_step_length(step_lengths[p]);
      send_idle_pct = idle_of[p / 2];
      stall_pct = stall_of[p / 2];
      drain_frames = (p == 2 || p == 3);
      gen_count = 1000;
      target = rand_items + 73;
      while (rand_items < target) gen_frame();
      // receiver holds off while the sender keeps offering
      if (p == 4) hold_req = hold_req + 1;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results for %0d transfers (%0d random) over %0d step_length writes",
             results_checked, items_accepted, rand_items, cfg_writes);
    $display("Fires rejected: %0d on a full buffer, %0d out of time order; peak store %0d",
             n_full, n_order, max_stored);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
